// File: sv/stc_pkg.sv
// Shared types, constants and microcode program of the senary to radix converter.
package stc_pkg;

    // Default store depth for the converted digits
    localparam int STC_MAX_DIGITS = 22;

    // Field widths of the items
    localparam int STC_CODE_W  = 27;
    localparam int STC_BASE_W  = 5;
    localparam int STC_CHAR_W  = 7;
    localparam int STC_VALUE_W = 22;
    localparam int STC_MUL_W   = 32;

    // Decimal digits of the code below the top one, and the smallest radix
    localparam int STC_LOW_DIGITS = 7;
    localparam logic [STC_BASE_W-1:0] STC_MIN_BASE = 5'd2;
    localparam logic [STC_BASE_W-1:0] STC_DECIMAL  = 5'd10;
    localparam logic [STC_CHAR_W-1:0] STC_CHAR_ZERO   = 7'd48;
    localparam logic [STC_CHAR_W-1:0] STC_CHAR_LETTER = 7'd55;

    // Powers of six, 6^0 to 6^7
    localparam logic [18:0] STC_POW6 [8] = '{
        19'd1, 19'd6, 19'd36, 19'd216, 19'd1296, 19'd7776, 19'd46656, 19'd279936
    };

    // floor(2^32 / d) for each divisor d; entries 0 and 1 are never selected
    localparam logic [STC_MUL_W-1:0] STC_RECIP [32] = '{
        32'h80000000, 32'h80000000, 32'h80000000, 32'h55555555,
        32'h40000000, 32'h33333333, 32'h2AAAAAAA, 32'h24924924,
        32'h20000000, 32'h1C71C71C, 32'h19999999, 32'h1745D174,
        32'h15555555, 32'h13B13B13, 32'h12492492, 32'h11111111,
        32'h10000000, 32'h0F0F0F0F, 32'h0E38E38E, 32'h0D79435E,
        32'h0CCCCCCC, 32'h0C30C30C, 32'h0BA2E8BA, 32'h0B21642C,
        32'h0AAAAAAA, 32'h0A3D70A3, 32'h09D89D89, 32'h097B425E,
        32'h09249249, 32'h08D3DCB0, 32'h08888888, 32'h08421084
    };

    // Payload of one input item and of one result item
    typedef struct packed {
        logic [STC_CODE_W-1:0] senary_code;
        logic [STC_BASE_W-1:0] target_base;
    } stc_in_t;

    typedef struct packed {
        logic [STC_CHAR_W-1:0] digit_char;
        logic                  is_last;
    } stc_out_t;

    // Microcode
    typedef logic [3:0] stc_addr_t;

    typedef enum logic [2:0] {
        OP_WAIT,   // wait for an item and load it
        OP_MUL,    // estimate quotient by reciprocal multiply
        OP_FIX,    // correct quotient, form remainder
        OP_ACC,    // add remainder times power of six
        OP_TOP,    // add top code digit, start radix phase
        OP_RD,     // read one stored digit
        OP_PUT     // load the output register
    } stc_op_t;

    typedef enum logic [2:0] {
        JC_NONE,
        JC_ALWAYS,
        JC_POS_MORE,
        JC_Q_NONZERO,
        JC_CNT_ONE
    } stc_cond_t;

    typedef struct packed {
        stc_op_t   op;
        logic      use_base;
        stc_cond_t cond;
        stc_addr_t target;
    } stc_ctrl_t;

    localparam stc_addr_t A_WAIT = 4'd0;
    localparam stc_addr_t A_MULD = 4'd1;
    localparam stc_addr_t A_FIXD = 4'd2;
    localparam stc_addr_t A_ACC  = 4'd3;
    localparam stc_addr_t A_TOP  = 4'd4;
    localparam stc_addr_t A_MULB = 4'd5;
    localparam stc_addr_t A_FIXB = 4'd6;
    localparam stc_addr_t A_RD0  = 4'd7;
    localparam stc_addr_t A_PUT  = 4'd8;
    localparam stc_addr_t A_RD   = 4'd9;

    // Control store
    function automatic stc_ctrl_t stc_ucode(input stc_addr_t a);
        stc_ctrl_t w;
        begin
            w = '{op: OP_WAIT, use_base: 1'b0, cond: JC_ALWAYS, target: A_WAIT};
            case (a)
                A_WAIT: w = '{op: OP_WAIT, use_base: 1'b0, cond: JC_NONE,      target: A_WAIT};
                A_MULD: w = '{op: OP_MUL,  use_base: 1'b0, cond: JC_NONE,      target: A_WAIT};
                A_FIXD: w = '{op: OP_FIX,  use_base: 1'b0, cond: JC_NONE,      target: A_WAIT};
                A_ACC:  w = '{op: OP_ACC,  use_base: 1'b0, cond: JC_POS_MORE,  target: A_MULD};
                A_TOP:  w = '{op: OP_TOP,  use_base: 1'b0, cond: JC_NONE,      target: A_WAIT};
                A_MULB: w = '{op: OP_MUL,  use_base: 1'b1, cond: JC_NONE,      target: A_WAIT};
                A_FIXB: w = '{op: OP_FIX,  use_base: 1'b1, cond: JC_Q_NONZERO, target: A_MULB};
                A_RD0:  w = '{op: OP_RD,   use_base: 1'b1, cond: JC_NONE,      target: A_WAIT};
                A_PUT:  w = '{op: OP_PUT,  use_base: 1'b1, cond: JC_CNT_ONE,   target: A_WAIT};
                A_RD:   w = '{op: OP_RD,   use_base: 1'b1, cond: JC_ALWAYS,    target: A_PUT};
                default: w = '{op: OP_WAIT, use_base: 1'b0, cond: JC_ALWAYS, target: A_WAIT};
            endcase
            return w;
        end
    endfunction

endpackage

// File: sv/stc_ifaces.sv
// Valid/ready channel interfaces for code items and digit items.
interface stc_number_if;
    import stc_pkg::*;

    logic    valid;
    logic    ready;
    stc_in_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface stc_digit_if;
    import stc_pkg::*;

    logic     valid;
    logic     ready;
    stc_out_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// File: sv/senary_to_radix_converter.sv
// Base-6 code to radix-N ASCII digit converter, microcoded datapath.
// Steps: load the item, weight the code digits, then find each output digit in the divide
// loop and send the digits in the emit loop; D digits per item (D up to 22 for radix 2),
// and the emit loop can be held by a stall from the digit channel.
// One item at a time; the weighting steps and the divide and emit loops set the pace.
// A new item is taken as soon as the last digit sits in the output register.
// Reset clears the step counter, digit count and output valid; the digit store is not cleared.
module senary_to_radix_converter #(
    parameter int MAX_DIGITS = stc_pkg::STC_MAX_DIGITS
) (
    input  logic               clk,
    input  logic               rst_n,
    stc_number_if.sink         number,
    stc_digit_if.source        digits
);
    import stc_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // Sequencer and datapath registers
    stc_addr_t                upc_reg, upc_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     out_valid_reg, out_valid_next;
    stc_out_t                 out_item_reg, out_item_next;
    logic [STC_CODE_W-1:0]    num_reg, num_next;
    logic [STC_CODE_W-1:0]    q_reg, q_next;
    logic [STC_VALUE_W-1:0]   value_reg, value_next;
    logic [STC_BASE_W-1:0]    base_reg, base_next;
    logic [STC_BASE_W-1:0]    rem_reg, rem_next;
    logic [2:0]               pos_reg, pos_next;
    logic [STC_BASE_W-1:0]    rd_reg;
    logic [STC_BASE_W-1:0]    digit_store [MAX_DIGITS];

    stc_ctrl_t                ctrl;
    logic                     stall;
    logic                     cond_hit;
    logic [STC_BASE_W-1:0]    div;
    logic [58:0]              prod;
    logic [31:0]              qb;
    logic [STC_CODE_W-1:0]    r_raw;
    logic [5:0]               r6;
    logic                     corr;
    logic [STC_BASE_W-1:0]    rem_fix;
    logic [STC_CODE_W-1:0]    q_fix;
    logic                     store_wr;
    logic [IDX_W-1:0]         rd_idx;
    logic [CNT_W-1:0]         cnt_dec;
    logic [23:0]              acc_term;
    logic [23:0]              top_term;

    assign ctrl = stc_ucode(upc_reg);

    // Divisor and quotient estimate/correction
    assign div   = ctrl.use_base ? base_reg : STC_DECIMAL;
    assign prod  = 59'(num_reg) * 59'(STC_RECIP[div]);
    assign qb    = 32'(q_reg) * 32'(div);
    assign r_raw = num_reg - qb[STC_CODE_W-1:0];
    assign r6    = r_raw[5:0];
    assign corr  = (r6 >= {1'b0, div});
    assign rem_fix = corr ? STC_BASE_W'(r6 - {1'b0, div}) : r6[STC_BASE_W-1:0];
    assign q_fix = q_reg + STC_CODE_W'(corr);

    assign acc_term = 24'(rem_reg) * 24'(STC_POW6[pos_reg]);
    assign top_term = 24'(num_reg[3:0]) * 24'(STC_POW6[STC_LOW_DIGITS]);

    assign cnt_dec  = cnt_reg - CNT_ONE;
    assign rd_idx   = cnt_dec[IDX_W-1:0];
    assign store_wr = (ctrl.op == OP_FIX) && ctrl.use_base && (cnt_reg < CNT_MAX);

    // Hold on an empty input or a full output register
    always_comb
    begin
        stall = 1'b0;
        case (ctrl.op)
            OP_WAIT: stall = !number.valid;
            OP_PUT:  stall = out_valid_reg && !digits.ready;
            default: stall = 1'b0;
        endcase
    end

    // Evaluate the jump condition
    always_comb
    begin
        case (ctrl.cond)
            JC_ALWAYS:    cond_hit = 1'b1;
            JC_POS_MORE:  cond_hit = (pos_reg != 3'(STC_LOW_DIGITS - 1));
            JC_Q_NONZERO: cond_hit = (q_fix != '0);
            JC_CNT_ONE:   cond_hit = (cnt_reg == CNT_ONE);
            default:      cond_hit = 1'b0;
        endcase
    end

    // Advance the step counter
    always_comb
    begin
        if (stall)
        begin
            upc_next = upc_reg;
        end
        else if (cond_hit)
        begin
            upc_next = ctrl.target;
        end
        else
        begin
            upc_next = upc_reg + 4'd1;
        end
    end

    // Datapath next values
    always_comb
    begin
        num_next       = num_reg;
        q_next         = q_reg;
        value_next     = value_reg;
        base_next      = base_reg;
        rem_next       = rem_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && !digits.ready;
        case (ctrl.op)
            OP_WAIT:
            begin
                num_next   = number.item.senary_code;
                base_next  = (number.item.target_base < STC_MIN_BASE) ?
                             STC_MIN_BASE : number.item.target_base;
                value_next = '0;
                pos_next   = '0;
                if (number.valid)
                begin
                    cnt_next = '0;
                end
            end
            OP_MUL:
            begin
                q_next = prod[58:32];
            end
            OP_FIX:
            begin
                num_next = q_fix;
                rem_next = rem_fix;
                if (store_wr)
                begin
                    cnt_next = cnt_reg + CNT_ONE;
                end
            end
            OP_ACC:
            begin
                value_next = value_reg + acc_term[STC_VALUE_W-1:0];
                pos_next   = pos_reg + 3'd1;
            end
            OP_TOP:
            begin
                num_next = STC_CODE_W'(value_reg + top_term[STC_VALUE_W-1:0]);
            end
            OP_PUT:
            begin
                if (!stall)
                begin
                    out_valid_next           = 1'b1;
                    out_item_next.digit_char = (rd_reg < STC_DECIMAL) ?
                        STC_CHAR_ZERO + STC_CHAR_W'(rd_reg) :
                        STC_CHAR_LETTER + STC_CHAR_W'(rd_reg);
                    out_item_next.is_last    = (cnt_reg == CNT_ONE);
                    cnt_next                 = cnt_dec;
                end
            end
            default:
            begin
                num_next = num_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= A_WAIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        q_reg        <= q_next;
        value_reg    <= value_next;
        base_reg     <= base_next;
        rem_reg      <= rem_next;
        pos_reg      <= pos_next;
        out_item_reg <= out_item_next;
    end

    // Digit store: write remainders, registered read for the emit loop
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            digit_store[cnt_reg[IDX_W-1:0]] <= rem_fix;
        end
        if (ctrl.op == OP_RD)
        begin
            rd_reg <= digit_store[rd_idx];
        end
    end

    assign number.ready = (ctrl.op == OP_WAIT);
    assign digits.valid = out_valid_reg;
    assign digits.item  = out_item_reg;

    // Digit count stays within the store
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("digit count beyond store depth");

    // Corrected remainder is below the divisor
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_FIX) |=> (rem_reg < $past(div)))
        else $error("remainder not below divisor");

    // The last digit returns the sequencer to the load step
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_PUT && !stall && cnt_reg == CNT_ONE) |=> (upc_reg == A_WAIT))
        else $error("sequencer did not finish after last digit");

    // Emit never starts with an empty store
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_RD) |-> (cnt_reg != '0))
        else $error("digit read with empty store");

endmodule
